### hdl/ccps_pkg.sv
// Shared types and constants for the contactor precharge sequencer.
`timescale 1ns / 1ps
`default_nettype none

package ccps_pkg;

   // Register file geometry
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr word bits
   localparam logic [1:0] REG_DELAY_TICKS     = 2'd0;
   localparam logic [1:0] REG_PRECHARGE_TICKS = 2'd1;
   localparam logic [1:0] REG_DISCHARGE_TICKS = 2'd2;
   localparam logic [1:0] REG_CHECK_ENABLES   = 2'd3;

   // Register reset values
   localparam logic [7:0] DELAY_TICKS_RST     = 8'h17;
   localparam logic [7:0] PRECHARGE_TICKS_RST = 8'h10;
   localparam logic [7:0] DISCHARGE_TICKS_RST = 8'h1F;
   localparam logic [3:0] CHECK_ENABLES_RST   = 4'h0;

   // Check enable bit positions
   localparam int CHK_BMS   = 0;
   localparam int CHK_IMD   = 1;
   localparam int CHK_PLUS  = 2;
   localparam int CHK_MINUS = 3;

   // Fault codes
   localparam logic [2:0] FAULT_GENERAL    = 3'd0;
   localparam logic [2:0] FAULT_BMS        = 3'd1;
   localparam logic [2:0] FAULT_IMD        = 3'd2;
   localparam logic [2:0] FAULT_PLUS_WELD  = 3'd3;
   localparam logic [2:0] FAULT_MINUS_WELD = 3'd4;
   localparam logic [2:0] FAULT_PLUS_LOSS  = 3'd5;
   localparam logic [2:0] FAULT_MINUS_LOSS = 3'd6;

   // Precharge status codes
   localparam logic [7:0] STATUS_NONE     = 8'h00;
   localparam logic [7:0] STATUS_STARTED  = 8'h0f;
   localparam logic [7:0] STATUS_COMPLETE = 8'hff;

   // Reported state code for panic
   localparam logic [2:0] TS_PANIC = 3'd5;

   typedef struct packed {
      logic [7:0] delay_ticks;
      logic [7:0] precharge_ticks;
      logic [7:0] discharge_ticks;
      logic [3:0] check_enables;
   } cfg_type;

   typedef struct packed {
      logic action;
      logic airplus_closed;
      logic airminus_closed;
      logic bms_ok;
      logic imd_ok;
      logic tsms_on;
      logic sense_mp;
      logic sense_hvd;
      logic sense_imd;
      logic sense_bms;
   } req_type;

   typedef struct packed {
      logic [2:0] ts_state;
      logic       precharge_relay;
      logic       minus_relay;
      logic [7:0] precharge_status;
      logic       panic_sent;
      logic [2:0] fault_id;
      logic [5:0] sense_flags;
      logic [1:0] aux_flags;
   } rsp_type;

endpackage

`default_nettype wire

### hdl/ccps_regs.sv
// APB configuration registers of the contactor precharge sequencer.
`timescale 1ns / 1ps
`default_nettype none

module ccps_regs
   import ccps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   logic [1:0] index;
   logic       wr_en;

   assign index  = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.delay_ticks     <= DELAY_TICKS_RST;
         cfg_ff.precharge_ticks <= PRECHARGE_TICKS_RST;
         cfg_ff.discharge_ticks <= DISCHARGE_TICKS_RST;
         cfg_ff.check_enables   <= CHECK_ENABLES_RST;
      end else if (wr_en) begin
         unique case (index)
            REG_DELAY_TICKS:     cfg_ff.delay_ticks     <= pwdata[7:0];
            REG_PRECHARGE_TICKS: cfg_ff.precharge_ticks <= pwdata[7:0];
            REG_DISCHARGE_TICKS: cfg_ff.discharge_ticks <= pwdata[7:0];
            REG_CHECK_ENABLES:   cfg_ff.check_enables   <= pwdata[3:0];
            default: ;
         endcase
      end
   end

   // Read mux
   always_comb begin
      prdata = '0;
      unique case (index)
         REG_DELAY_TICKS:     prdata[7:0] = cfg_ff.delay_ticks;
         REG_PRECHARGE_TICKS: prdata[7:0] = cfg_ff.precharge_ticks;
         REG_DISCHARGE_TICKS: prdata[7:0] = cfg_ff.discharge_ticks;
         REG_CHECK_ENABLES:   prdata[3:0] = cfg_ff.check_enables;
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### hdl/ccps_seq.sv
// Sequencer state, fault checks and result formation for one item.
`timescale 1ns / 1ps
`default_nettype none

module ccps_seq
   import ccps_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output rsp_type      result
);

   typedef enum logic [2:0] {
      MODE_DEENERGIZED = 3'd0,
      MODE_DELAY       = 3'd1,
      MODE_PRECHARGING = 3'd2,
      MODE_ENERGIZED   = 3'd3,
      MODE_DISCHARGING = 3'd4,
      MODE_PANIC       = 3'd5
   } mode_type;

   mode_type   mode_ff,      mode_in;
   logic [7:0] tick_ff,      tick_in;
   logic       pre_on_ff,    pre_on_in;
   logic       minus_on_ff,  minus_on_in;
   logic [7:0] status_ff,    status_in;
   logic [2:0] code;

   // Enabled checks, first failure wins
   always_comb begin
      priority if (cfg.check_enables[CHK_BMS] &&
                   ((item.bms_ok && item.sense_mp && !item.sense_bms) ||
                    (!item.bms_ok && item.sense_bms)))
         code = FAULT_BMS;
      else if (cfg.check_enables[CHK_IMD] &&
               ((item.imd_ok && item.sense_bms && !item.sense_imd) ||
                (!item.imd_ok && item.sense_imd)))
         code = FAULT_IMD;
      else if (cfg.check_enables[CHK_PLUS] && item.airplus_closed && !item.tsms_on)
         code = FAULT_PLUS_WELD;
      else if (cfg.check_enables[CHK_PLUS] && !item.airplus_closed && item.tsms_on)
         code = FAULT_PLUS_LOSS;
      else if (cfg.check_enables[CHK_MINUS] && !minus_on_ff && item.airminus_closed)
         code = FAULT_MINUS_WELD;
      else if (cfg.check_enables[CHK_MINUS] && minus_on_ff && !item.airminus_closed)
         code = FAULT_MINUS_LOSS;
      else
         code = FAULT_GENERAL;
   end

   // Next state and result
   always_comb begin
      mode_in     = mode_ff;
      tick_in     = tick_ff;
      pre_on_in   = pre_on_ff;
      minus_on_in = minus_on_ff;
      status_in   = status_ff;
      result      = '0;

      if (!item.action) begin
         // timer tick: saturating count
         if (tick_ff != 8'hff) tick_in = tick_ff + 8'd1;
      end else begin
         result.sense_flags = {item.imd_ok, item.bms_ok, item.sense_imd,
                               item.sense_bms, item.sense_hvd, item.sense_mp};
         result.aux_flags   = {item.airminus_closed, item.airplus_closed};

         if (code != FAULT_GENERAL || mode_ff == MODE_PANIC) begin
            mode_in           = MODE_PANIC;
            pre_on_in         = 1'b0;
            minus_on_in       = 1'b0;
            result.panic_sent = 1'b1;
            result.fault_id   = code;
         end else begin
            unique case (mode_ff)
               MODE_DEENERGIZED: begin
                  pre_on_in   = 1'b0;
                  minus_on_in = 1'b0;
                  if (item.airplus_closed) begin
                     mode_in = MODE_DELAY;
                     tick_in = '0;
                  end
               end
               MODE_DELAY: begin
                  if (!item.airplus_closed) begin
                     mode_in = MODE_DEENERGIZED;
                  end else if (tick_ff > cfg.delay_ticks) begin
                     mode_in   = MODE_PRECHARGING;
                     status_in = STATUS_STARTED;
                     pre_on_in = 1'b1;
                     tick_in   = '0;
                  end
               end
               MODE_PRECHARGING: begin
                  if (!item.airplus_closed) begin
                     mode_in   = MODE_DISCHARGING;
                     pre_on_in = 1'b0;
                     status_in = STATUS_NONE;
                     tick_in   = '0;
                  end else if (tick_ff > cfg.precharge_ticks) begin
                     mode_in     = MODE_ENERGIZED;
                     minus_on_in = 1'b1;
                     pre_on_in   = 1'b0;
                     status_in   = STATUS_COMPLETE;
                  end
               end
               MODE_ENERGIZED: begin
                  if (!item.airplus_closed) begin
                     mode_in     = MODE_DISCHARGING;
                     minus_on_in = 1'b0;
                     status_in   = STATUS_NONE;
                     tick_in     = '0;
                  end
               end
               MODE_DISCHARGING: begin
                  if (tick_ff > cfg.discharge_ticks) mode_in = MODE_DEENERGIZED;
               end
               default: ;
            endcase
         end
      end

      result.ts_state         = mode_in;
      result.precharge_relay  = pre_on_in;
      result.minus_relay      = minus_on_in;
      result.precharge_status = status_in;
   end

   // State registers, advanced once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DEENERGIZED;
         tick_ff     <= '0;
         pre_on_ff   <= 1'b0;
         minus_on_ff <= 1'b0;
         status_ff   <= STATUS_NONE;
      end else if (step) begin
         mode_ff     <= mode_in;
         tick_ff     <= tick_in;
         pre_on_ff   <= pre_on_in;
         minus_on_ff <= minus_on_in;
         status_ff   <= status_in;
      end
   end

endmodule

`default_nettype wire

### hdl/contactor_precharge_sequencer_core.sv
// Top level of the contactor precharge sequencer: input and result registers.
// An accepted item passes through the input register, then the result
// register. Throughput: one item per cycle while results are taken; the
// result register frees as it is taken.
// Reset (synchronous, active high) empties both registers, puts the sequencer
// in deenergized with relays open and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module contactor_precharge_sequencer_core
   import ccps_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // item input
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire req_type               req_data,
   // result output
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output rsp_type                    rsp_data,
   // configuration
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    advance;
   cfg_type cfg;
   rsp_type result;

   ccps_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ccps_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Handshake: item moves on when the result register is free or being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   // Panic report always comes with both relays open
   a_panic_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.panic_sent |-> !rsp_data.precharge_relay && !rsp_data.minus_relay)
      else $error("panic reported with a relay closed");

   // A specific fault code only accompanies a panic report
   a_fault_panic: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.fault_id != FAULT_GENERAL |-> rsp_data.panic_sent)
      else $error("fault code without panic");

   // Precharge relay and minus contactor are never driven together
   a_relay_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.precharge_relay && rsp_data.minus_relay))
      else $error("precharge relay and minus contactor both closed");

   // Panic on an evaluation is reported as panic state
   a_panic_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.panic_sent |-> rsp_data.ts_state == TS_PANIC)
      else $error("panic report outside panic state");

endmodule

`default_nettype wire
